/* design/nfpa_pkg.sv */
// Shared types and codes for the next-fit page run allocator.
package nfpa_pkg;

  // Default number of page entries in the map memories
  localparam int unsigned NUM_PAGES_DEF = 4096;

  // Field widths fixed by the interface
  localparam int unsigned PAGE_W   = 36;
  localparam int unsigned COUNT_W  = 13;
  localparam int unsigned FUNC_W   = 2;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned CFG_IDX_W = 1;

  // Request function codes
  localparam logic [FUNC_W-1:0] FUNC_ALLOC   = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_FREE    = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_RESERVE = 2'd2;

  // Result status codes
  localparam logic [STATUS_W-1:0] STATUS_DONE      = 3'd0;
  localparam logic [STATUS_W-1:0] STATUS_TOO_LONG  = 3'd1;
  localparam logic [STATUS_W-1:0] STATUS_NO_RUN    = 3'd2;
  localparam logic [STATUS_W-1:0] STATUS_OUT_RANGE = 3'd3;
  localparam logic [STATUS_W-1:0] STATUS_NOT_ALLOC = 3'd4;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_PAGE    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_REGION_PAGES = 1'b1;

  // Register reset values
  localparam logic [PAGE_W-1:0]  BASE_PAGE_RESET    = 36'd0;
  localparam logic [COUNT_W-1:0] REGION_PAGES_RESET = 13'd4096;

  // Controller states
  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RANGE,
    ST_SCAN,
    ST_MARK,
    ST_CHECK,
    ST_UNMARK,
    ST_RESERVE,
    ST_FINISH
  } state_t;

  // Write controls for the two page map memories
  typedef struct packed {
    logic alloc_we;
    logic alloc_bit;
    logic resv_we;
    logic resv_bit;
  } mem_wr_t;

endpackage

/* design/nfpa_page_mem.sv */
// Allocated and reserved page maps: two 1-bit synchronous memories.
module nfpa_page_mem #(
  parameter int unsigned NUM_PAGES = nfpa_pkg::NUM_PAGES_DEF,
  parameter int unsigned AW        = $clog2(NUM_PAGES)
) (
  input  logic             clk,
  input  nfpa_pkg::mem_wr_t wr,
  input  logic [AW-1:0]    wr_addr,
  input  logic [AW-1:0]    rd_addr,
  output logic             rd_alloc,
  output logic             rd_resv
);

  logic alloc_mem [NUM_PAGES];
  logic resv_mem  [NUM_PAGES];

  // Write the allocated map
  always_ff @(posedge clk) begin
    if (wr.alloc_we) begin
      alloc_mem[wr_addr] <= wr.alloc_bit;
    end
  end

  // Write the reserved map
  always_ff @(posedge clk) begin
    if (wr.resv_we) begin
      resv_mem[wr_addr] <= wr.resv_bit;
    end
  end

  // Registered reads
  always_ff @(posedge clk) begin
    rd_alloc <= alloc_mem[rd_addr];
    rd_resv  <= resv_mem[rd_addr];
  end

endmodule

/* design/next_fit_page_run_allocator.sv */
// Top level of the next-fit page run allocator: controller, registers and map memory.
// Allocate: the scan reads one page per cycle over at most two laps of the region,
// then marks one page per cycle. Free runs a check pass, then a clear pass; reserve
// runs a single set pass.
// One transaction at a time; busy stays high until the result strobe is issued.
// After reset a clearing pass writes every map entry, with busy high.
// The receiver cannot stall: each result is shown for exactly one cycle.
module next_fit_page_run_allocator #(
  parameter int unsigned NUM_PAGES = nfpa_pkg::NUM_PAGES_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // request channel
  input  logic                               start,
  output logic                               busy,
  input  logic [nfpa_pkg::FUNC_W-1:0]        in_func,
  input  logic [nfpa_pkg::COUNT_W-1:0]       in_num_pages,
  input  logic [nfpa_pkg::PAGE_W-1:0]        in_page_number,
  // result channel
  output logic                               out_strobe,
  output logic [nfpa_pkg::STATUS_W-1:0]      out_status,
  output logic [nfpa_pkg::PAGE_W-1:0]        out_first_page,
  output logic [nfpa_pkg::COUNT_W-1:0]       out_used_pages,
  // configuration write port
  input  logic                               cfg_we,
  input  logic [nfpa_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [nfpa_pkg::PAGE_W-1:0]        cfg_wdata
);

  localparam int unsigned AW  = $clog2(NUM_PAGES);
  localparam int unsigned LW  = $clog2(NUM_PAGES + 1);
  localparam int unsigned CW  = (LW > nfpa_pkg::COUNT_W) ? LW : nfpa_pkg::COUNT_W;
  localparam int unsigned PW  = nfpa_pkg::PAGE_W;
  localparam int unsigned NW  = nfpa_pkg::COUNT_W;
  localparam int unsigned SW  = nfpa_pkg::STATUS_W;
  localparam int unsigned FW  = nfpa_pkg::FUNC_W;
  localparam logic [CW-1:0] NUM_PAGES_C = CW'(NUM_PAGES);
  localparam logic [CW-1:0] LAST_PAGE_C = CW'(NUM_PAGES - 1);

  // Configuration registers
  logic [PW-1:0] base_r;
  logic [NW-1:0] region_r;

  // Controller registers
  nfpa_pkg::state_t state_r, state_nxt;
  logic [FW-1:0]  func_r, func_nxt;
  logic [NW-1:0]  n_r, n_nxt;
  logic [PW:0]    off_r, off_nxt;
  logic [AW-1:0]  sp_r, sp_nxt;
  logic [CW-1:0]  used_r, used_nxt;
  logic [AW-1:0]  pos_r, pos_nxt;
  logic [1:0]     lap_r, lap_nxt;
  logic [AW-1:0]  p_r, p_nxt;
  logic [CW-1:0]  run_len_r, run_len_nxt;
  logic [AW-1:0]  run_start_r, run_start_nxt;
  logic [AW-1:0]  start_r, start_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;
  logic           q_vld_r, q_vld_nxt;
  logic [AW-1:0]  q_pos_r, q_pos_nxt;
  logic [1:0]     q_lap_r, q_lap_nxt;
  logic [AW-1:0]  wr_addr_r, wr_addr_nxt;
  logic [SW-1:0]  status_r, status_nxt;
  logic           alloc_ok_r, alloc_ok_nxt;
  logic           out_strobe_r, out_strobe_nxt;
  logic [SW-1:0]  out_status_r, out_status_nxt;
  logic [PW-1:0]  out_first_r, out_first_nxt;
  logic [NW-1:0]  out_used_r, out_used_nxt;

  // Memory interface
  nfpa_pkg::mem_wr_t wr;
  logic [AW-1:0]     rd_addr;
  logic              rd_alloc;
  logic              rd_resv;

  // Derived values
  logic [CW-1:0] len_c;
  logic [AW-1:0] p_in;
  logic [CW-1:0] run_eff;
  logic [CW-1:0] run_inc;
  logic          page_free;
  logic          range_bad;

  nfpa_page_mem #(
    .NUM_PAGES (NUM_PAGES),
    .AW        (AW)
  ) u_page_mem (
    .clk      (clk),
    .wr       (wr),
    .wr_addr  (wr_addr_r),
    .rd_addr  (rd_addr),
    .rd_alloc (rd_alloc),
    .rd_resv  (rd_resv)
  );

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r   <= nfpa_pkg::BASE_PAGE_RESET;
      region_r <= nfpa_pkg::REGION_PAGES_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        nfpa_pkg::CFG_BASE_PAGE:    base_r   <= cfg_wdata;
        nfpa_pkg::CFG_REGION_PAGES: region_r <= cfg_wdata[NW-1:0];
        default: ;
      endcase
    end
  end

  // Effective region length, stale search position and scan helpers
  assign len_c     = (CW'(region_r) > NUM_PAGES_C) ? NUM_PAGES_C : CW'(region_r);
  assign p_in      = (CW'(sp_r) < len_c) ? sp_r : '0;
  assign run_eff   = (q_pos_r == '0) ? '0 : run_len_r;
  assign run_inc   = run_eff + CW'(1);
  assign page_free = !rd_alloc && !rd_resv;
  assign range_bad = off_r[PW] ||
                     (({1'b0, off_r[PW-1:0]} + (PW+1)'(n_r)) > (PW+1)'(len_c));

  // State register and datapath registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= nfpa_pkg::ST_CLEAR;
      wr_addr_r    <= '0;
      sp_r         <= '0;
      used_r       <= '0;
      q_vld_r      <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      wr_addr_r    <= wr_addr_nxt;
      sp_r         <= sp_nxt;
      used_r       <= used_nxt;
      q_vld_r      <= q_vld_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    func_r       <= func_nxt;
    n_r          <= n_nxt;
    off_r        <= off_nxt;
    pos_r        <= pos_nxt;
    lap_r        <= lap_nxt;
    p_r          <= p_nxt;
    run_len_r    <= run_len_nxt;
    run_start_r  <= run_start_nxt;
    start_r      <= start_nxt;
    cnt_r        <= cnt_nxt;
    q_pos_r      <= q_pos_nxt;
    q_lap_r      <= q_lap_nxt;
    status_r     <= status_nxt;
    alloc_ok_r   <= alloc_ok_nxt;
    out_status_r <= out_status_nxt;
    out_first_r  <= out_first_nxt;
    out_used_r   <= out_used_nxt;
  end

  // Next state and outputs
  always_comb begin
    state_nxt      = state_r;
    func_nxt       = func_r;
    n_nxt          = n_r;
    off_nxt        = off_r;
    sp_nxt         = sp_r;
    used_nxt       = used_r;
    pos_nxt        = pos_r;
    lap_nxt        = lap_r;
    p_nxt          = p_r;
    run_len_nxt    = run_len_r;
    run_start_nxt  = run_start_r;
    start_nxt      = start_r;
    cnt_nxt        = cnt_r;
    q_vld_nxt      = 1'b0;
    q_pos_nxt      = q_pos_r;
    q_lap_nxt      = q_lap_r;
    wr_addr_nxt    = wr_addr_r;
    status_nxt     = status_r;
    alloc_ok_nxt   = alloc_ok_r;
    out_strobe_nxt = 1'b0;
    out_status_nxt = out_status_r;
    out_first_nxt  = out_first_r;
    out_used_nxt   = out_used_r;
    wr             = '0;
    rd_addr        = pos_r;

    case (state_r)
      // Sweep both maps to zero after reset
      nfpa_pkg::ST_CLEAR: begin
        wr          = '{alloc_we: 1'b1, alloc_bit: 1'b0, resv_we: 1'b1, resv_bit: 1'b0};
        wr_addr_nxt = wr_addr_r + AW'(1);
        if (CW'(wr_addr_r) == LAST_PAGE_C) begin
          state_nxt = nfpa_pkg::ST_IDLE;
        end
      end

      // Take a request and sort out the cases that need no map access
      nfpa_pkg::ST_IDLE: begin
        if (start) begin
          func_nxt     = in_func;
          n_nxt        = in_num_pages;
          off_nxt      = {1'b0, in_page_number} - {1'b0, base_r};
          status_nxt   = nfpa_pkg::STATUS_DONE;
          alloc_ok_nxt = 1'b0;
          start_nxt    = p_in;
          case (in_func)
            nfpa_pkg::FUNC_ALLOC: begin
              if (CW'(in_num_pages) > len_c) begin
                status_nxt = nfpa_pkg::STATUS_TOO_LONG;
                state_nxt  = nfpa_pkg::ST_FINISH;
              end else if (len_c == '0) begin
                status_nxt = nfpa_pkg::STATUS_NO_RUN;
                state_nxt  = nfpa_pkg::ST_FINISH;
              end else if (in_num_pages == '0) begin
                alloc_ok_nxt = 1'b1;
                sp_nxt       = p_in;
                state_nxt    = nfpa_pkg::ST_FINISH;
              end else begin
                pos_nxt     = p_in;
                p_nxt       = p_in;
                lap_nxt     = 2'd0;
                run_len_nxt = '0;
                state_nxt   = nfpa_pkg::ST_SCAN;
              end
            end
            nfpa_pkg::FUNC_FREE,
            nfpa_pkg::FUNC_RESERVE: begin
              state_nxt = nfpa_pkg::ST_RANGE;
            end
            default: begin
              state_nxt = nfpa_pkg::ST_FINISH;
            end
          endcase
        end
      end

      // Check that a free or reserve run lies inside the region
      nfpa_pkg::ST_RANGE: begin
        if (range_bad) begin
          status_nxt = nfpa_pkg::STATUS_OUT_RANGE;
          state_nxt  = nfpa_pkg::ST_FINISH;
        end else if (n_r == '0) begin
          state_nxt = nfpa_pkg::ST_FINISH;
        end else begin
          start_nxt   = off_r[AW-1:0];
          wr_addr_nxt = off_r[AW-1:0];
          pos_nxt     = off_r[AW-1:0];
          cnt_nxt     = CW'(n_r);
          run_len_nxt = CW'(n_r);
          state_nxt   = (func_r == nfpa_pkg::FUNC_FREE) ? nfpa_pkg::ST_CHECK
                                                         : nfpa_pkg::ST_RESERVE;
        end
      end

      // Read one page per cycle; the current free run is tracked from the read data in the cycle after each read
      nfpa_pkg::ST_SCAN: begin
        q_vld_nxt = 1'b1;
        q_pos_nxt = pos_r;
        q_lap_nxt = lap_r;
        if (CW'(pos_r) + CW'(1) == len_c) begin
          pos_nxt = '0;
          lap_nxt = (lap_r == 2'd2) ? 2'd2 : lap_r + 2'd1;
        end else begin
          pos_nxt = pos_r + AW'(1);
        end
        if (q_vld_r) begin
          if (q_lap_r == 2'd2 ||
              (q_lap_r == 2'd1 && q_pos_r >= p_r && run_eff == '0)) begin
            // every start has been tried
            status_nxt = nfpa_pkg::STATUS_NO_RUN;
            state_nxt  = nfpa_pkg::ST_FINISH;
            q_vld_nxt  = 1'b0;
          end else if (page_free) begin
            run_len_nxt = run_inc;
            if (run_eff == '0) begin
              run_start_nxt = q_pos_r;
            end
            if (run_inc == CW'(n_r)) begin
              start_nxt    = (run_eff == '0) ? q_pos_r : run_start_r;
              sp_nxt       = (run_eff == '0) ? q_pos_r : run_start_r;
              wr_addr_nxt  = (run_eff == '0) ? q_pos_r : run_start_r;
              used_nxt     = used_r + CW'(n_r);
              cnt_nxt      = CW'(n_r);
              alloc_ok_nxt = 1'b1;
              state_nxt    = nfpa_pkg::ST_MARK;
              q_vld_nxt    = 1'b0;
            end
          end else begin
            run_len_nxt = '0;
          end
        end
      end

      // Mark the found run allocated
      nfpa_pkg::ST_MARK: begin
        wr          = '{alloc_we: 1'b1, alloc_bit: 1'b1, resv_we: 1'b0, resv_bit: 1'b0};
        wr_addr_nxt = wr_addr_r + AW'(1);
        cnt_nxt     = cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          state_nxt = nfpa_pkg::ST_FINISH;
        end
      end

      // Verify every page of the run is allocated before freeing
      nfpa_pkg::ST_CHECK: begin
        if (cnt_r != '0) begin
          q_vld_nxt = 1'b1;
          pos_nxt   = pos_r + AW'(1);
          cnt_nxt   = cnt_r - CW'(1);
        end
        if (q_vld_r) begin
          if (!rd_alloc) begin
            status_nxt = nfpa_pkg::STATUS_NOT_ALLOC;
            state_nxt  = nfpa_pkg::ST_FINISH;
            q_vld_nxt  = 1'b0;
          end else if (run_len_r == CW'(1)) begin
            cnt_nxt     = CW'(n_r);
            wr_addr_nxt = start_r;
            used_nxt    = (used_r >= CW'(n_r)) ? used_r - CW'(n_r) : '0;
            state_nxt   = nfpa_pkg::ST_UNMARK;
            q_vld_nxt   = 1'b0;
          end else begin
            run_len_nxt = run_len_r - CW'(1);
          end
        end
      end

      // Clear the allocated bits of the run
      nfpa_pkg::ST_UNMARK: begin
        wr          = '{alloc_we: 1'b1, alloc_bit: 1'b0, resv_we: 1'b0, resv_bit: 1'b0};
        wr_addr_nxt = wr_addr_r + AW'(1);
        cnt_nxt     = cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          state_nxt = nfpa_pkg::ST_FINISH;
        end
      end

      // Set the reserved bits of the run
      nfpa_pkg::ST_RESERVE: begin
        wr          = '{alloc_we: 1'b0, alloc_bit: 1'b0, resv_we: 1'b1, resv_bit: 1'b1};
        wr_addr_nxt = wr_addr_r + AW'(1);
        cnt_nxt     = cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          state_nxt = nfpa_pkg::ST_FINISH;
        end
      end

      // Load the result registers and strobe the transaction
      nfpa_pkg::ST_FINISH: begin
        out_strobe_nxt = 1'b1;
        out_status_nxt = status_r;
        out_first_nxt  = alloc_ok_r ? base_r + PW'(start_r) : '0;
        out_used_nxt   = used_r[NW-1:0];
        state_nxt      = nfpa_pkg::ST_IDLE;
      end

      default: begin
        state_nxt = nfpa_pkg::ST_IDLE;
      end
    endcase
  end

  assign busy           = (state_r != nfpa_pkg::ST_IDLE);
  assign out_strobe     = out_strobe_r;
  assign out_status     = out_status_r;
  assign out_first_page = out_first_r;
  assign out_used_pages = out_used_r;

  // A result strobe lasts one cycle and the next needs a new transaction
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe)
    else $error("result strobe held for two cycles");

  // The used page count never exceeds the map size
  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= NUM_PAGES_C)
    else $error("used page count above map size");

  // An accepted transaction keeps the block busy in the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == nfpa_pkg::ST_IDLE && start) |=> busy)
    else $error("accepted transaction did not raise busy");

  // Marking an allocated run stays inside the region
  a_mark_in_region: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == nfpa_pkg::ST_MARK) |-> (CW'(wr_addr_r) < len_c))
    else $error("allocated run crosses the region end");

endmodule
